[rtl/xds_pkg.sv]
// ----------------------------------------------------------------------------
// xds_pkg
// Types, codes and sizes shared by the XOR distance shortlist block.
// ----------------------------------------------------------------------------
`default_nettype none

package xds_pkg;

    localparam int XDS_LIST_DEPTH = 20;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_OFFER = 2'd1;
    localparam logic [1:0] CMD_TAKE  = 2'd2;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_GIVEN     = 3'd3,
        ST_NONE_LEFT = 3'd4,
        ST_CLEARED   = 3'd5
    } xds_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_PLACE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_TAKE_SCAN,
        S_TAKE_RD,
        S_DONE
    } xds_state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] node_id;
        logic [15:0] node_handle;
    } xds_in_t;

    typedef struct packed {
        xds_status_t status;
        logic [63:0] out_node_id;
        logic [15:0] out_handle;
        logic [4:0]  fill_count;
    } xds_out_t;

    // one stored contact
    typedef struct packed {
        logic [63:0] distance;
        logic [15:0] hnd;
    } xds_ent_t;

    typedef struct packed {
        logic     en;
        xds_ent_t data;
    } xds_wr_t;

endpackage

`default_nettype wire

[rtl/xds_store.sv]
// ----------------------------------------------------------------------------
// xds_store
// Entry memory: distance and handle per slot, one write and one registered
// read port.
// ----------------------------------------------------------------------------
`default_nettype none

module xds_store #(
    parameter int LIST_DEPTH = xds_pkg::XDS_LIST_DEPTH,
    parameter int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  wire                   clk,
    input  xds_pkg::xds_wr_t      wr,
    input  wire  [IDX_W-1:0]      wr_addr,
    input  wire  [IDX_W-1:0]      rd_addr,
    output xds_pkg::xds_ent_t     rd_data
);
    import xds_pkg::*;

    xds_ent_t mem [LIST_DEPTH];
    xds_ent_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/xds_ctrl.sv]
// ----------------------------------------------------------------------------
// xds_ctrl
// Command sequencer: scans, shifts and inserts entries one step a cycle,
// keeps the fill count and queried marks, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module xds_ctrl #(
    parameter int LIST_DEPTH = xds_pkg::XDS_LIST_DEPTH,
    parameter int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
    parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire  [63:0]           target,
    input  wire                   cmd_valid,
    output logic                  cmd_stall,
    input  xds_pkg::xds_in_t      cmd_item,
    output logic                  rsp_valid,
    input  wire                   rsp_stall,
    output xds_pkg::xds_out_t     rsp_item,
    output xds_pkg::xds_wr_t      wr,
    output logic [IDX_W-1:0]      wr_addr,
    output logic [IDX_W-1:0]      rd_addr,
    input  xds_pkg::xds_ent_t     rd_data
);
    import xds_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    xds_state_t            state_reg, state_next;
    logic [63:0]           dist_reg, dist_next;
    logic [15:0]           hnd_reg, hnd_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      m_reg, m_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [LIST_DEPTH-1:0] queried_reg, queried_next;
    xds_status_t           res_st_reg, res_st_next;
    logic [63:0]           res_id_reg, res_id_next;
    logic [15:0]           res_hnd_reg, res_hnd_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    xds_out_t              rsp_item_reg, rsp_item_next;

    logic [CNT_W-1:0]      m_dec;
    logic [CNT_W-1:0]      grown;
    logic                  dist_eq, dist_gt;

    // shared compare and step units
    assign dist_eq = (rd_data.distance == dist_reg);
    assign dist_gt = (rd_data.distance > dist_reg);
    assign m_dec   = m_reg - 1'b1;
    assign grown   = (count_reg == DEPTH_C) ? count_reg : count_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            queried_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            queried_reg   <= queried_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg     <= dist_next;
        hnd_reg      <= hnd_next;
        idx_reg      <= idx_next;
        m_reg        <= m_next;
        res_st_reg   <= res_st_next;
        res_id_reg   <= res_id_next;
        res_hnd_reg  <= res_hnd_next;
        rsp_item_reg <= rsp_item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        dist_next      = dist_reg;
        hnd_next       = hnd_reg;
        idx_next       = idx_reg;
        m_next         = m_reg;
        count_next     = count_reg;
        queried_next   = queried_reg;
        res_st_next    = res_st_reg;
        res_id_next    = res_id_reg;
        res_hnd_next   = res_hnd_reg;
        rsp_item_next  = rsp_item_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd_stall      = (state_reg != S_IDLE);
        rd_addr        = idx_reg[IDX_W-1:0];
        wr_addr        = idx_reg[IDX_W-1:0];
        wr.en          = 1'b0;
        wr.data.distance = dist_reg;
        wr.data.hnd    = hnd_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    dist_next    = cmd_item.node_id ^ target;
                    hnd_next     = cmd_item.node_handle;
                    idx_next     = '0;
                    res_id_next  = '0;
                    res_hnd_next = '0;
                    if (cmd_item.cmd == CMD_CLEAR)
                    begin
                        count_next   = '0;
                        queried_next = '0;
                        res_st_next  = ST_CLEARED;
                        state_next   = S_DONE;
                    end
                    else if (cmd_item.cmd == CMD_OFFER)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_TAKE_SCAN;
                    end
                end
            end

            S_SCAN_RD:
            begin
                state_next = (idx_reg == count_reg) ? S_PLACE : S_SCAN_CMP;
            end

            S_SCAN_CMP:
            begin
                if (dist_eq)
                begin
                    res_st_next = ST_DUPLICATE;
                    state_next  = S_DONE;
                end
                else if (dist_gt)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end

            S_PLACE:
            begin
                // idx_reg is the insert position; past the end means too far
                if (idx_reg == DEPTH_C)
                begin
                    res_st_next = ST_DROPPED;
                    state_next  = S_DONE;
                end
                else
                begin
                    count_next = grown;
                    m_next     = grown - 1'b1;
                    state_next = ((grown - 1'b1) > idx_reg) ? S_SHIFT_RD : S_INSERT;
                end
            end

            S_SHIFT_RD:
            begin
                rd_addr    = m_dec[IDX_W-1:0];
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                // move entry m-1 back to slot m
                wr.en        = 1'b1;
                wr.data      = rd_data;
                wr_addr      = m_reg[IDX_W-1:0];
                queried_next[m_reg[IDX_W-1:0]] = queried_reg[m_dec[IDX_W-1:0]];
                m_next       = m_dec;
                state_next   = (m_dec > idx_reg) ? S_SHIFT_RD : S_INSERT;
            end

            S_INSERT:
            begin
                wr.en        = 1'b1;
                queried_next[idx_reg[IDX_W-1:0]] = 1'b0;
                res_st_next  = ST_INSERTED;
                state_next   = S_DONE;
            end

            S_TAKE_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    res_st_next = ST_NONE_LEFT;
                    state_next  = S_DONE;
                end
                else if (!queried_reg[idx_reg[IDX_W-1:0]])
                begin
                    queried_next[idx_reg[IDX_W-1:0]] = 1'b1;
                    state_next = S_TAKE_RD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_TAKE_RD:
            begin
                res_st_next  = ST_GIVEN;
                res_id_next  = rd_data.distance ^ target;
                res_hnd_next = rd_data.hnd;
                state_next   = S_DONE;
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_item_next.status      = res_st_reg;
                    rsp_item_next.out_node_id = res_id_reg;
                    rsp_item_next.out_handle  = res_hnd_reg;
                    rsp_item_next.fill_count  = 5'(count_reg);
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("fill count above list depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && cmd_item.cmd == CMD_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the list");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside completion step");

    a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_WR) |-> (m_reg > idx_reg))
        else $error("shift write at or below insert position");

endmodule

`default_nettype wire

[rtl/xor_distance_shortlist.sv]
// ----------------------------------------------------------------------------
// xor_distance_shortlist
// Bounded contact list sorted by XOR distance to a configured target.
// ----------------------------------------------------------------------------
// One command item at a time: clear, offer or take, each giving one result
// item. The entries sit in a single-port-read memory and a sequencer walks
// them one slot per step, so the time a command takes follows the list. An
// offer scans from the nearest entry until it finds a duplicate, a farther
// entry or the end of the list; it then lands ahead of the farther entry and
// moves the entries behind it back, is appended, or is dropped from a full
// list. A take scans past the queried entries to the nearest unqueried one,
// or reports none left. The completion step waits while the previous result
// stays stalled. A result waits in its own register, so the next command is
// taken while an earlier result is still stalled. No clearing pass is needed
// after reset.
`default_nettype none

module xor_distance_shortlist #(
    parameter int LIST_DEPTH = xds_pkg::XDS_LIST_DEPTH
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cmd_valid,
    output logic                  cmd_stall,
    input  xds_pkg::xds_in_t      cmd_item,
    output logic                  rsp_valid,
    input  wire                   rsp_stall,
    output xds_pkg::xds_out_t     rsp_item,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [63:0]           cfg_data
);
    import xds_pkg::*;

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    logic [63:0]      target_reg;
    xds_wr_t          wr;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    xds_ent_t         rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            target_reg <= cfg_data;
        end
    end

    xds_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .target    (target_reg),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .wr        (wr),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    xds_store #(
        .LIST_DEPTH (LIST_DEPTH),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire
